// ===== rtl/gnns_pkg.sv =====
// ----------------------------------------------------------------------------
// gnns_pkg
// Shared types, constants and helper functions for the nearest-neighbour
// glyph scaler: size clamping, run boundaries and the column expansion.
// ----------------------------------------------------------------------------
package gnns_pkg;

    // Largest scaled cell edge in pixels.
    localparam int MAX_CELL_SIZE = 32;
    // Rows and columns of a source glyph.
    localparam int SRC_ROWS      = 8;
    localparam int SRC_W         = 8;
    localparam int SIZE_W        = 6;
    localparam int ROW_COUNT_W   = 3;
    localparam int ROW_BITS_W    = 32;
    localparam int ROW_INDEX_W   = 5;
    localparam int TDATA_OUT_W   = 40;
    localparam int PROD_W        = 10;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SRC_ROWS);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_CELL_SIZE);

    // One non-empty run of scaled rows produced by one source row.
    typedef struct packed {
        logic [ROW_BITS_W-1:0] bits;
        logic [SIZE_W-1:0]     first;
        logic [SIZE_W-1:0]     run_end;
        logic                  glyph_end;
    } gnns_run_t;

    // A size of zero acts as one; anything above the largest cell saturates.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        s = size;
        if (s == '0)
        begin
            s = SIZE_W'(1);
        end
        if (s > SIZE_MAX)
        begin
            s = SIZE_MAX;
        end
        return s;
    endfunction

    // First scaled index that maps to source index idx: ceil(idx*size/8).
    function automatic logic [SIZE_W-1:0] col_bound(input logic [3:0] idx,
                                                    input logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(idx) * PROD_W'(size) + PROD_W'(SRC_ROWS - 1);
        return prod[SIZE_W+2:3];
    endfunction

    // Left-aligned scaled row: column c copies source bit floor(8c/size),
    // which is the source bit whose boundary range holds c.
    function automatic logic [ROW_BITS_W-1:0] scale_word(input logic [SRC_W-1:0] src,
                                                         input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0]     bnd [0:SRC_W];
        logic [ROW_BITS_W-1:0] word;
        logic [SIZE_W-1:0]     col;
        word = '0;
        for (int j = 0; j <= SRC_W; j++)
        begin
            bnd[j] = col_bound(4'(j), size);
        end
        for (int c = 0; c < ROW_BITS_W; c++)
        begin
            col = SIZE_W'(c);
            for (int j = 0; j < SRC_W; j++)
            begin
                if (src[SRC_W-1-j] && (col >= bnd[j]) && (col < bnd[j+1]))
                begin
                    word[ROW_BITS_W-1-c] = 1'b1;
                end
            end
        end
        return word;
    endfunction

endpackage

// ===== rtl/gnns_front.sv =====
// ----------------------------------------------------------------------------
// gnns_front
// Holds the cell size, accepts source rows, counts them within the glyph and
// turns each into a run descriptor with its expanded row word.
// ----------------------------------------------------------------------------
module gnns_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [gnns_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gnns_pkg::SRC_W-1:0]    s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output gnns_pkg::gnns_run_t           q_entry
);
    import gnns_pkg::*;

    logic [SIZE_W-1:0]      size_reg;
    logic [ROW_COUNT_W-1:0] count_reg;
    logic [SIZE_W-1:0]      size_eff;
    logic [SIZE_W-1:0]      first;
    logic [SIZE_W-1:0]      run_end;
    logic                   accept;

    // Runs are bounded by the column map applied to the row counter.
    assign size_eff = eff_size(size_reg);
    assign first    = col_bound({1'b0, count_reg}, size_eff);
    assign run_end  = col_bound({1'b0, count_reg} + 4'd1, size_eff);

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Empty runs advance the counter but queue nothing.
    assign q_push            = accept && (first != run_end);
    assign q_entry.bits      = scale_word(s_tdata, size_eff);
    assign q_entry.first     = first;
    assign q_entry.run_end   = run_end;
    assign q_entry.glyph_end = (run_end == size_eff);

    // Size register and source row counter; the counter wraps after row seven.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_reg + ROW_COUNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/gnns_queue.sv =====
// ----------------------------------------------------------------------------
// gnns_queue
// Two-entry queue of run descriptors between the front and the back end.
// ----------------------------------------------------------------------------
module gnns_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gnns_pkg::gnns_run_t  push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output gnns_pkg::gnns_run_t  head
);
    import gnns_pkg::*;

    gnns_run_t   mem [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // The front must never overrun the queue, nor the back read it empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("queue popped while empty");

endmodule

// ===== rtl/gnns_back.sv =====
// ----------------------------------------------------------------------------
// gnns_back
// Row sequencer: takes one run at a time from the queue and issues its scaled
// rows, one per cycle while the output accepts them, through an output register.
// ----------------------------------------------------------------------------
module gnns_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  gnns_pkg::gnns_run_t                q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gnns_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import gnns_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    gnns_run_t              run_reg;
    logic [SIZE_W-1:0]      row_reg;
    logic [SIZE_W-1:0]      row_next;
    logic                   out_valid_reg;
    logic [ROW_BITS_W-1:0]  out_bits_reg;
    logic [ROW_INDEX_W-1:0] out_index_reg;
    logic                   out_last_reg;
    logic                   out_gend_reg;
    logic                   emit;
    logic                   run_done;

    // A row goes out when the output register is free or being drained.
    assign emit     = busy_reg && (!out_valid_reg || m_tready);
    assign run_done = emit && ((row_reg + SIZE_W'(1)) == run_reg.run_end);
    assign q_pop    = q_not_empty && (!busy_reg || run_done);

    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (emit)
        begin
            row_next = row_reg + SIZE_W'(1);
        end
        if (run_done)
        begin
            busy_next = 1'b0;
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            row_next  = q_head.first;
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        if (q_pop)
        begin
            run_reg <= q_head;
        end
        if (emit)
        begin
            out_bits_reg  <= run_reg.bits;
            out_index_reg <= row_reg[ROW_INDEX_W-1:0];
            out_last_reg  <= (row_reg + SIZE_W'(1)) == run_reg.run_end;
            out_gend_reg  <= ((row_reg + SIZE_W'(1)) == run_reg.run_end) && run_reg.glyph_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-ROW_BITS_W-ROW_INDEX_W){1'b0}}, out_index_reg, out_bits_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_gend_reg;

    // The current row always lies inside the run being issued.
    a_row_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (row_reg < run_reg.run_end))
        else $error("row counter left its run");

    // The end of a glyph is always the end of a run.
    a_glyph_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_gend_reg) |-> out_last_reg)
        else $error("glyph end without run end");

endmodule

// ===== rtl/glyph_nearest_neighbour_scaler_core.sv =====
// ----------------------------------------------------------------------------
// glyph_nearest_neighbour_scaler_core
// Scales 8x8 one-bit glyphs to a square cell by nearest-neighbour sampling.
//
//   Channel  Dir  Signals                     Word
//   cfg      in   cfg_valid/ready/data        cell size (0 acts as 1, >32 as 32)
//   s        in   s_tvalid/tready/tdata       one source row, bit 7 leftmost
//   m        out  m_tvalid/tready/tdata/...   one scaled row
//
// Each source row yields zero to four scaled rows, four at size 32, issued
// one per cycle by the back-end row sequencer unless the output stalls.
// A two-entry run queue lets the front keep accepting while rows wait on a
// stalled output. Reset sets the size to 8 and restarts the glyph at its
// first source row. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module glyph_nearest_neighbour_scaler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gnns_pkg::SIZE_W-1:0]        cfg_data,    // glyph_size
    // Source rows.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gnns_pkg::SRC_W-1:0]         s_tdata,     // source_row
    // Scaled rows.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gnns_pkg::TDATA_OUT_W-1:0]   m_tdata,     // row_bits[31:0], row_index[36:32]
    output logic                               m_tlast,     // last_of_run
    output logic                               m_tuser      // last_of_glyph
);
    import gnns_pkg::*;

    gnns_run_t push_entry;
    gnns_run_t head;
    logic      push;
    logic      pop;
    logic      full;
    logic      not_empty;

    // Size writes are always taken.
    assign cfg_ready = 1'b1;

    gnns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    gnns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    gnns_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbour glyph scaler. It streams
// source glyph rows across many cell sizes, including out-of-range sizes and
// size changes in the middle of a glyph. A scoreboard predicts every scaled
// row and compares it field by field with the output stream. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gnns_pkg::*;

    // One scaled row as it leaves the block.
    typedef struct {
        logic [ROW_BITS_W-1:0]  bits;
        logic [ROW_INDEX_W-1:0] index;
        logic                   run_last;
        logic                   glyph_last;
    } scaled_row_t;

    // Predicts the scaled rows of each source row and checks the output.
    class glyph_row_scoreboard;
        logic [SIZE_W-1:0]      cell_size;
        logic [ROW_COUNT_W-1:0] src_row_count;
        logic [SIZE_W-1:0]      next_out_row;
        scaled_row_t            pending_rows[$];
        int                     mismatches;
        int                     rows_in;
        int                     rows_out;

        function new();
            cell_size     = SIZE_W'(SRC_ROWS);
            src_row_count = '0;
            next_out_row  = '0;
            mismatches    = 0;
            rows_in       = 0;
            rows_out      = 0;
        endfunction

        function void set_cell_size(input logic [SIZE_W-1:0] size);
            cell_size = size;
        endfunction

        function int rows_waiting();
            return pending_rows.size();
        endfunction

        // Work out every scaled row that one accepted source row causes.
        function void note_source_row(input logic [SRC_W-1:0] src);
            int          size;
            int          s;
            int          first_row;
            int          end_row;
            int          sbit;
            int          n;
            logic [31:0] word;
            scaled_row_t row;
            size = int'(cell_size);
            // A zero size acts as one; larger than the cell maximum saturates.
            if (size == 0)
            begin
                size = 1;
            end
            if (size > MAX_CELL_SIZE)
            begin
                size = MAX_CELL_SIZE;
            end
            s = int'(src_row_count);
            first_row = (s * size + 7) / SRC_ROWS;
            end_row   = ((s + 1) * size + 7) / SRC_ROWS;
            if (end_row > size)
            begin
                end_row = size;
            end
            // Column c samples source bit floor(8c/size), leftmost pixel at bit 31.
            word = '0;
            for (int c = 0; c < size; c++)
            begin
                sbit = (c * SRC_ROWS) / size;
                if (src[7 - sbit])
                begin
                    word[31 - c] = 1'b1;
                end
            end
            n = 0;
            for (int r = first_row; r < end_row && n < 4; r++)
            begin
                row.bits       = word;
                row.index      = ROW_INDEX_W'(r);
                row.run_last   = (r + 1 == end_row);
                row.glyph_last = (r + 1 == size);
                pending_rows.push_back(row);
                n++;
            end
            // The glyph always ends after its eighth source row.
            if (s == SRC_ROWS - 1)
            begin
                src_row_count = '0;
                next_out_row  = '0;
            end
            else
            begin
                src_row_count = ROW_COUNT_W'(s + 1);
                next_out_row  = SIZE_W'(end_row);
            end
            rows_in++;
        endfunction

        // Compare one output word against the oldest predicted row.
        function void check_scaled_row(input logic [ROW_BITS_W-1:0]  bits,
                                       input logic [ROW_INDEX_W-1:0] index,
                                       input logic                   run_last,
                                       input logic                   glyph_last);
            scaled_row_t want;
            rows_out++;
            if (pending_rows.size() == 0)
            begin
                $error("unexpected scaled row: row_bits %h, row_index %0d", bits, index);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            if (bits !== want.bits)
            begin
                $error("row_bits mismatch: expected %h, actual %h", want.bits, bits);
                mismatches++;
            end
            if (index !== want.index)
            begin
                $error("row_index mismatch: expected %0d, actual %0d", want.index, index);
                mismatches++;
            end
            if (run_last !== want.run_last)
            begin
                $error("last_of_run mismatch: expected %b, actual %b",
                       want.run_last, run_last);
                mismatches++;
            end
            if (glyph_last !== want.glyph_last)
            begin
                $error("last_of_glyph mismatch: expected %b, actual %b",
                       want.glyph_last, glyph_last);
                mismatches++;
            end
        endfunction
    endclass

    // Cycles allowed for the block to settle once the last row has left.
    localparam int SETTLE_CYCLES = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SIZE_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SRC_W-1:0]       s_tdata;        // source_row
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;        // row_bits[31:0], row_index[36:32]
    logic                   m_tlast;        // last_of_run
    logic                   m_tuser;        // last_of_glyph

    bit                     idle_on;
    int                     size_writes;
    glyph_row_scoreboard    sb = new();

    glyph_nearest_neighbour_scaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // Output side: ready drops in random bursts while idling is enabled.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Check every word accepted on the output side.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_scaled_row(m_tdata[31:0], m_tdata[36:32], m_tlast, m_tuser);
        end
    end

    // Write the cell size register; only called while the block is idle.
    task automatic write_cell_size(input logic [SIZE_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_cell_size(size);
        size_writes++;
    endtask

    // Offer one source row, with an occasional idle gap in front of it.
    task automatic send_source_row(input logic [SRC_W-1:0] row);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_source_row(row);
    endtask

    // Stop sending and hold off until every predicted row has come out.
    task automatic drain_rows();
        s_tvalid <= 1'b0;
        while (sb.rows_waiting() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random row content, with the all-zero, all-one and single-pixel rows mixed in.
    function automatic logic [SRC_W-1:0] random_row();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80 >> $urandom_range(0, 7);
            default: return SRC_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Main sequence.
    initial
    begin
        logic [SRC_W-1:0]  directed_rows [8];
        logic [SIZE_W-1:0] phase_size;
        int                phase_rows;
        int                random_sent;
        int                phase_no;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_on     = 1'b1;
        size_writes = 0;
        directed_rows = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h81, 8'h7E};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size of 8: one scaled row per source row.
        foreach (directed_rows[i])
        begin
            send_source_row(directed_rows[i]);
        end
        drain_rows();

        // Size zero acts as one: only the first source row yields a row.
        write_cell_size(6'd0);
        send_source_row(8'hFF);
        send_source_row(8'h80);
        send_source_row(8'h01);
        drain_rows();

        // Size above the cell maximum saturates, and the change lands mid-glyph.
        write_cell_size(6'd33);
        for (int i = 0; i < 5; i++)
        begin
            send_source_row(directed_rows[i + 2]);
        end
        drain_rows();

        // Largest legal size: four rows per source row.
        write_cell_size(6'd32);
        foreach (directed_rows[i])
        begin
            send_source_row(directed_rows[7 - i]);
        end
        drain_rows();

        // Random phases: extremes first, then random sizes and lengths.
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < 104)
        begin
            case (phase_no)
                0:       phase_size = 6'd1;
                1:       phase_size = 6'd63;
                2:       phase_size = 6'd7;
                3:       phase_size = 6'd9;
                default: phase_size = SIZE_W'($urandom_range(0, 63));
            endcase
            phase_rows = $urandom_range(5, 24);
            write_cell_size(phase_size);
            for (int i = 0; i < phase_rows; i++)
            begin
                send_source_row(random_row());
            end
            drain_rows();
            random_sent += phase_rows;
            phase_no++;
        end

        // Closing phase at full speed with no idling on either side.
        // Any ready burst already under way finishes first.
        idle_on = 1'b0;
        @(posedge clk);
        wait (m_tready);
        write_cell_size(6'd32);
        for (int i = 0; i < 16; i++)
        begin
            send_source_row(random_row());
        end
        drain_rows();

        $display("Run covered %0d source rows and %0d scaled rows over %0d size writes,",
                 sb.rows_in, sb.rows_out, size_writes);
        $display("including sizes 0, 1, 32, 33 and 63 and size changes within a glyph.");
        if (sb.mismatches == 0 && sb.rows_waiting() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gnns_pkg.sv
rtl/gnns_front.sv
rtl/gnns_queue.sv
rtl/gnns_back.sv
rtl/glyph_nearest_neighbour_scaler_core.sv
tb/testbench.sv
